@@ sv/message_frame_decoder_defines.svh @@
// Assertion macros for the message frame decoder.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef MESSAGE_FRAME_DECODER_DEFINES_SVH
`define MESSAGE_FRAME_DECODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mfd_pkg.sv @@
package mfd_pkg;

	// Frame layout and limits
	localparam int unsigned HEADER_BYTES = 20;
	localparam logic [31:0] FIELD_LIMIT  = 32'd64;
	localparam logic [31:0] BODY_LIMIT   = 32'd1048576;
	localparam int unsigned POS_W        = 22;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam int unsigned QUEUE_DEPTH  = 4;

	// Parse phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_WIDE   = 3'd1;
	localparam logic [2:0] PH_NARROW = 3'd2;
	localparam logic [2:0] PH_BODY   = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// Header word slots
	localparam logic [2:0] HW_VERSION = 3'd0;
	localparam logic [2:0] HW_TYPE    = 3'd1;
	localparam logic [2:0] HW_WIDE    = 3'd2;
	localparam logic [2:0] HW_NARROW  = 3'd3;

	// Result kinds
	localparam logic [2:0] KIND_TYPE   = 3'd0;
	localparam logic [2:0] KIND_WIDE   = 3'd1;
	localparam logic [2:0] KIND_NARROW = 3'd2;
	localparam logic [2:0] KIND_BODY   = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TRUNC    = 3'd1;
	localparam logic [2:0] ST_VERSION  = 3'd2;
	localparam logic [2:0] ST_TYPE     = 3'd3;
	localparam logic [2:0] ST_OVERSIZE = 3'd4;
	localparam logic [2:0] ST_TRAILING = 3'd5;

	// Configuration register map
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE_TYPE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDE_FIELDS   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_NARROW_FIELDS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_BYTES    = 3'd4;

	typedef struct packed {
		logic [31:0] expected_version;
		logic [31:0] max_message_type;
		logic [6:0]  max_wide_fields;
		logic [6:0]  max_narrow_fields;
		logic [20:0] max_body_bytes;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		expected_version:  32'd1,
		max_message_type:  32'd15,
		max_wide_fields:   7'd64,
		max_narrow_fields: 7'd64,
		max_body_bytes:    21'd1048576
	};

	// One queue entry: at most one data item, then optionally the closing status
	typedef struct packed {
		logic        has_item;
		logic [2:0]  kind;
		logic [19:0] index;
		logic [63:0] value;
		logic        has_status;
		logic [2:0]  status;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [2:0]  item_kind;
		logic [19:0] item_index;
		logic [63:0] item_value;
		logic [2:0]  status_code;
		logic        is_final;
	} result_t;

	// Next section with a nonzero length after phase ph
	function automatic logic [2:0] after_phase(input logic [2:0] ph, input logic [6:0] wide,
			input logic [6:0] narrow, input logic [20:0] body);
		logic [2:0] nxt;
		nxt = PH_DONE;
		if (ph < PH_BODY && body != '0)
			nxt = PH_BODY;
		if (ph < PH_NARROW && narrow != '0)
			nxt = PH_NARROW;
		if (ph < PH_WIDE && wide != '0)
			nxt = PH_WIDE;
		return nxt;
	endfunction

endpackage

@@ sv/mfd_byte_if.sv @@
interface mfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_payload;

	modport source(output valid, output data_byte, output end_of_payload, input ready);
	modport sink(input valid, input data_byte, input end_of_payload, output ready);
endinterface

@@ sv/mfd_item_if.sv @@
interface mfd_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [19:0] item_index;
	logic [63:0] item_value;
	logic [2:0]  status_code;
	logic        is_final;

	modport source(output valid, output item_kind, output item_index, output item_value,
		output status_code, output is_final, input ready);
	modport sink(input valid, input item_kind, input item_index, input item_value,
		input status_code, input is_final, output ready);
endinterface

@@ sv/mfd_cfg_if.sv @@
interface mfd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mfd_pkg::CFG_INDEX_W-1:0] reg_index;
	logic [31:0]                     write_data;

	modport source(output valid, output reg_index, output write_data, input ready);
	modport sink(input valid, input reg_index, input write_data, output ready);
endinterface

@@ sv/message_frame_decoder.sv @@
// Streaming decoder for little-endian framed messages.
// bytes: one payload byte per request, end_of_payload set on the last byte.
// items: decoded type, wide fields, narrow fields and body bytes as they
//   complete, then one status request (is_final = 1) closing each payload.
//   The consumer drops the data requests of a payload whose status is not ok.
// cfg: register writes (index, data); ready is always high. Write only while
//   the decoder is idle. Unknown indexes are ignored.
// Throughput: one byte per cycle while the queue is not full. A byte that
//   completes a data item and also ends the payload yields two requests;
//   the output side sends them in turn, absorbed by the four-entry queue
//   between parser and output. A byte is written into the queue at its
//   accepting edge; the output register loads it when it reaches the head of
//   the queue and the output is free, and its first request is valid from then on.
// A stalled consumer fills the queue; bytes.ready drops when it is full.
// Reset: registers return to their defaults, parser state, queue and output
//   register are cleared; no clearing pass is needed.
`include "message_frame_decoder_defines.svh"

module message_frame_decoder #(
	parameter logic [31:0] FIELD_LIMIT = mfd_pkg::FIELD_LIMIT,
	parameter logic [31:0] BODY_LIMIT  = mfd_pkg::BODY_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	mfd_cfg_if.sink    cfg,
	mfd_byte_if.sink   bytes,
	mfd_item_if.source items
);

	mfd_pkg::cfg_t      cfg_q;
	mfd_pkg::q_status_t q_status;
	mfd_pkg::entry_t    q_entry;
	mfd_pkg::entry_t    rd_entry;
	logic               q_push;
	logic               q_pop;
	logic               last_take;
	logic               status_out;
	logic               pop_pair;
	logic               item_out;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mfd_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				mfd_pkg::REG_EXPECTED_VERSION:  cfg_q.expected_version  <= cfg.write_data;
				mfd_pkg::REG_MAX_MESSAGE_TYPE:  cfg_q.max_message_type  <= cfg.write_data;
				mfd_pkg::REG_MAX_WIDE_FIELDS:   cfg_q.max_wide_fields   <= cfg.write_data[6:0];
				mfd_pkg::REG_MAX_NARROW_FIELDS: cfg_q.max_narrow_fields <= cfg.write_data[6:0];
				mfd_pkg::REG_MAX_BODY_BYTES:    cfg_q.max_body_bytes    <= cfg.write_data[20:0];
				default: ;
			endcase
		end
	end

	mfd_front #(
		.FIELD_LIMIT (FIELD_LIMIT),
		.BODY_LIMIT  (BODY_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.cfg      (cfg_q),
		.q_status (q_status),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	mfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_entry),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.status   (q_status)
	);

	mfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.rd_entry (rd_entry),
		.pop      (q_pop),
		.items    (items)
	);

	// Checks
	assign last_take  = bytes.valid && bytes.ready && bytes.end_of_payload;
	assign status_out = items.valid && items.item_kind == mfd_pkg::KIND_STATUS;
	assign pop_pair   = q_pop && rd_entry.has_item && rd_entry.has_status;
	assign item_out   = items.valid && !items.is_final;

	`MFD_ASSERT_NOW(a_no_overflow, q_push, !q_status.full, "queue push while full")
	`MFD_ASSERT_NOW(a_last_byte_status, last_take, q_push && q_entry.has_status, "no status queued")
	`MFD_ASSERT_NOW(a_status_is_final, status_out, items.is_final, "status without final mark")
	`MFD_ASSERT_NEXT(a_item_before_status, pop_pair, item_out, "data item not ahead of status")

endmodule

@@ sv/mfd_front.sv @@
// Front end: takes one byte per cycle while the queue is not full, runs the frame
// parser and pushes at most one queue entry per byte.
module mfd_front #(
	parameter logic [31:0] FIELD_LIMIT = mfd_pkg::FIELD_LIMIT,
	parameter logic [31:0] BODY_LIMIT  = mfd_pkg::BODY_LIMIT
) (
	input  logic             clk,
	input  logic             arst_n,
	mfd_byte_if.sink         bytes,
	input  mfd_pkg::cfg_t    cfg,
	input  mfd_pkg::q_status_t q_status,
	output logic             q_push,
	output mfd_pkg::entry_t  q_entry
);

	localparam logic [2:0] WIDE_ALIGN = 3'(mfd_pkg::HEADER_BYTES % 8);

	logic [2:0]                 phase_q, phase_n;
	logic [mfd_pkg::POS_W-1:0]  pos_q, pos_n;
	logic [63:0]                acc_q, acc_n;
	logic [20:0]                sec_q, sec_n;
	logic [6:0]                 wide_cnt_q, wide_cnt_n;
	logic [6:0]                 narrow_cnt_q, narrow_cnt_n;
	logic [20:0]                body_len_q, body_len_n;
	logic [2:0]                 err_q, err_n;

	logic        accept;
	logic        last;
	logic [2:0]  k;
	logic [63:0] acc_base;
	logic [31:0] w;
	logic [20:0] sec_inc;
	logic [31:0] eff_wide, eff_narrow, eff_body;
	logic        has_item;
	logic [2:0]  item_kind;
	logic [19:0] item_index;
	logic [63:0] item_value;
	logic [2:0]  status;

	assign bytes.ready = !q_status.full;
	assign accept      = bytes.valid && bytes.ready;
	assign last        = bytes.end_of_payload;

	// Count limits clipped to the built-in maxima
	always_comb begin
		eff_wide   = (32'(cfg.max_wide_fields) > FIELD_LIMIT) ?
			FIELD_LIMIT : 32'(cfg.max_wide_fields);
		eff_narrow = (32'(cfg.max_narrow_fields) > FIELD_LIMIT) ?
			FIELD_LIMIT : 32'(cfg.max_narrow_fields);
		eff_body   = (32'(cfg.max_body_bytes) > BODY_LIMIT) ?
			BODY_LIMIT : 32'(cfg.max_body_bytes);
	end

	// Byte lane inside the current word
	always_comb begin
		if (phase_q == mfd_pkg::PH_WIDE)
			k = pos_q[2:0] - WIDE_ALIGN;
		else
			k = {1'b0, pos_q[1:0]};
		acc_base = (k == 3'd0) ? '0 : acc_q;
		acc_n    = acc_base | (64'(bytes.data_byte) << {k, 3'b000});
		w        = acc_n[31:0];
		sec_inc  = sec_q + 21'd1;
	end

	// Parser next state
	always_comb begin
		phase_n      = phase_q;
		sec_n        = sec_q;
		wide_cnt_n   = wide_cnt_q;
		narrow_cnt_n = narrow_cnt_q;
		body_len_n   = body_len_q;
		err_n        = err_q;
		has_item     = 1'b0;
		item_kind    = mfd_pkg::KIND_TYPE;
		item_index   = '0;
		item_value   = '0;
		status       = mfd_pkg::ST_OK;

		if (err_q == mfd_pkg::ST_OK) begin
			case (phase_q)
				mfd_pkg::PH_HEADER: begin
					if (k == 3'd3) begin
						case (pos_q[4:2])
							mfd_pkg::HW_VERSION: begin
								if (w != cfg.expected_version)
									err_n = mfd_pkg::ST_VERSION;
							end
							mfd_pkg::HW_TYPE: begin
								if (w == '0 || w > cfg.max_message_type) begin
									err_n = mfd_pkg::ST_TYPE;
								end else begin
									has_item   = 1'b1;
									item_kind  = mfd_pkg::KIND_TYPE;
									item_value = 64'(w);
								end
							end
							mfd_pkg::HW_WIDE: begin
								if (w > eff_wide)
									err_n = mfd_pkg::ST_OVERSIZE;
								else
									wide_cnt_n = w[6:0];
							end
							mfd_pkg::HW_NARROW: begin
								if (w > eff_narrow)
									err_n = mfd_pkg::ST_OVERSIZE;
								else
									narrow_cnt_n = w[6:0];
							end
							default: begin
								// body length word closes the header
								if (w > eff_body) begin
									err_n = mfd_pkg::ST_OVERSIZE;
								end else begin
									body_len_n = w[20:0];
									sec_n      = '0;
									phase_n    = mfd_pkg::after_phase(mfd_pkg::PH_HEADER,
										wide_cnt_q, narrow_cnt_q, w[20:0]);
								end
							end
						endcase
					end
				end
				mfd_pkg::PH_WIDE, mfd_pkg::PH_NARROW: begin
					if ((phase_q == mfd_pkg::PH_WIDE && k == 3'd7) ||
							(phase_q == mfd_pkg::PH_NARROW && k == 3'd3)) begin
						has_item   = 1'b1;
						item_kind  = (phase_q == mfd_pkg::PH_WIDE) ?
							mfd_pkg::KIND_WIDE : mfd_pkg::KIND_NARROW;
						item_index = sec_q[19:0];
						item_value = acc_n;
						sec_n      = sec_inc;
						if (sec_inc >= 21'((phase_q == mfd_pkg::PH_WIDE) ?
								wide_cnt_q : narrow_cnt_q)) begin
							sec_n   = '0;
							phase_n = mfd_pkg::after_phase(phase_q, wide_cnt_q,
								narrow_cnt_q, body_len_q);
						end
					end
				end
				mfd_pkg::PH_BODY: begin
					has_item   = 1'b1;
					item_kind  = mfd_pkg::KIND_BODY;
					item_index = sec_q[19:0];
					item_value = 64'(bytes.data_byte);
					sec_n      = sec_inc;
					if (sec_inc >= body_len_q) begin
						sec_n   = '0;
						phase_n = mfd_pkg::PH_DONE;
					end
				end
				default: begin
					// any byte after the last section
					err_n = mfd_pkg::ST_TRAILING;
				end
			endcase
		end

		pos_n = (pos_q != mfd_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;

		// Closing status; short payloads win over everything else
		if (pos_n < mfd_pkg::POS_W'(mfd_pkg::HEADER_BYTES))
			status = mfd_pkg::ST_TRUNC;
		else if (err_n != mfd_pkg::ST_OK)
			status = err_n;
		else if (phase_n != mfd_pkg::PH_DONE)
			status = mfd_pkg::ST_TRUNC;
		else
			status = mfd_pkg::ST_OK;
	end

	// Queue entry
	assign q_push = accept && (has_item || last);
	always_comb begin
		q_entry.has_item   = has_item;
		q_entry.kind       = item_kind;
		q_entry.index      = item_index;
		q_entry.value      = item_value;
		q_entry.has_status = last;
		q_entry.status     = status;
	end

	// Parser state; everything returns to reset at the end of a payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= mfd_pkg::PH_HEADER;
			pos_q        <= '0;
			acc_q        <= '0;
			sec_q        <= '0;
			wide_cnt_q   <= '0;
			narrow_cnt_q <= '0;
			body_len_q   <= '0;
			err_q        <= mfd_pkg::ST_OK;
		end else if (accept) begin
			if (last) begin
				phase_q      <= mfd_pkg::PH_HEADER;
				pos_q        <= '0;
				acc_q        <= '0;
				sec_q        <= '0;
				wide_cnt_q   <= '0;
				narrow_cnt_q <= '0;
				body_len_q   <= '0;
				err_q        <= mfd_pkg::ST_OK;
			end else begin
				phase_q      <= phase_n;
				pos_q        <= pos_n;
				acc_q        <= (err_q == mfd_pkg::ST_OK) ? acc_n : acc_q;
				sec_q        <= sec_n;
				wide_cnt_q   <= wide_cnt_n;
				narrow_cnt_q <= narrow_cnt_n;
				body_len_q   <= body_len_n;
				err_q        <= err_n;
			end
		end
	end

endmodule

@@ sv/mfd_queue.sv @@
// Small FIFO that decouples the parser from the output side.
module mfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mfd_pkg::entry_t    wr_entry,
	input  logic               pop,
	output mfd_pkg::entry_t    rd_entry,
	output mfd_pkg::q_status_t status
);

	localparam int unsigned DEPTH = mfd_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	mfd_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rd_entry     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ sv/mfd_back.sv @@
// Back end: pops queue entries and serializes each into one or two requests
// through an output register.
module mfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mfd_pkg::q_status_t q_status,
	input  mfd_pkg::entry_t    rd_entry,
	output logic               pop,
	mfd_item_if.source         items
);

	logic             out_valid_q;
	mfd_pkg::result_t res_q;
	logic             pend_q;
	logic [2:0]       pend_status_q;
	logic             load_ok;
	mfd_pkg::result_t item_res, status_res, pend_res;

	assign load_ok = !out_valid_q || items.ready;
	assign pop     = load_ok && !pend_q && !q_status.empty;

	// Candidate requests
	always_comb begin
		item_res.item_kind   = rd_entry.kind;
		item_res.item_index  = rd_entry.index;
		item_res.item_value  = rd_entry.value;
		item_res.status_code = mfd_pkg::ST_OK;
		item_res.is_final    = 1'b0;

		status_res.item_kind   = mfd_pkg::KIND_STATUS;
		status_res.item_index  = '0;
		status_res.item_value  = '0;
		status_res.status_code = rd_entry.status;
		status_res.is_final    = 1'b1;

		pend_res             = status_res;
		pend_res.status_code = pend_status_q;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load_ok) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!q_status.empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= rd_entry.has_item && rd_entry.has_status;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_q) begin
				res_q <= pend_res;
			end else if (!q_status.empty) begin
				res_q         <= rd_entry.has_item ? item_res : status_res;
				pend_status_q <= rd_entry.status;
			end
		end
	end

	assign items.valid       = out_valid_q;
	assign items.item_kind   = res_q.item_kind;
	assign items.item_index  = res_q.item_index;
	assign items.item_value  = res_q.item_value;
	assign items.status_code = res_q.status_code;
	assign items.is_final    = res_q.is_final;

endmodule

@@ tb/mfd_frame_checker.sv @@
module mfd_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	mfd_cfg_if          cfg,
	mfd_byte_if         bytes,
	mfd_item_if         items,
	output int unsigned errors,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	mfd_pkg::cfg_t    regs;
	logic [2:0]       phase;
	logic [21:0]      pos;
	logic [63:0]      acc;
	logic [20:0]      sect;
	logic [6:0]       n_wide;
	logic [6:0]       n_narrow;
	logic [20:0]      body_len;
	logic [2:0]       err;
	int unsigned      mismatches = 0;
	mfd_pkg::result_t expected_items[$];

	function automatic logic [31:0] cap(input logic [31:0] r, input logic [31:0] lim);
		return (r > lim) ? lim : r;
	endfunction

	// first non-empty section after ph
	function automatic logic [2:0] section_after(input logic [2:0] ph);
		if (ph < mfd_pkg::PH_WIDE && n_wide != '0)
			return mfd_pkg::PH_WIDE;
		if (ph < mfd_pkg::PH_NARROW && n_narrow != '0)
			return mfd_pkg::PH_NARROW;
		if (ph < mfd_pkg::PH_BODY && body_len != '0)
			return mfd_pkg::PH_BODY;
		return mfd_pkg::PH_DONE;
	endfunction

	task automatic clear_frame();
		phase = mfd_pkg::PH_HEADER;
		pos = '0;
		acc = '0;
		sect = '0;
		n_wide = '0;
		n_narrow = '0;
		body_len = '0;
		err = mfd_pkg::ST_OK;
	endtask

	task automatic expect_item(input logic [2:0] kind, input logic [19:0] idx,
			input logic [63:0] val, input logic [2:0] st, input logic fin);
		mfd_pkg::result_t r;
		r.item_kind = kind;
		r.item_index = idx;
		r.item_value = val;
		r.status_code = st;
		r.is_final = fin;
		expected_items = {expected_items, r};
	endtask

	// predict the items caused by one accepted byte
	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic [2:0]  k;
		logic [31:0] w;
		logic [21:0] rel;
		logic        wide;
		logic [2:0]  st;
		if (err == mfd_pkg::ST_OK) begin
			case (phase)
			mfd_pkg::PH_HEADER: begin
				k = {1'b0, pos[1:0]};
				if (k == '0)
					acc = '0;
				acc = acc | (64'(b) << (8 * k));
				if (k == 3'd3) begin
					w = acc[31:0];
					// header words sit below byte 20
					case (pos[4:2])
					mfd_pkg::HW_VERSION: begin
						if (w != regs.expected_version)
							err = mfd_pkg::ST_VERSION;
					end
					mfd_pkg::HW_TYPE: begin
						if (w == '0 || w > regs.max_message_type)
							err = mfd_pkg::ST_TYPE;
						else
							expect_item(mfd_pkg::KIND_TYPE, '0, 64'(w), mfd_pkg::ST_OK, 1'b0);
					end
					mfd_pkg::HW_WIDE: begin
						if (w > cap(32'(regs.max_wide_fields), mfd_pkg::FIELD_LIMIT))
							err = mfd_pkg::ST_OVERSIZE;
						else
							n_wide = w[6:0];
					end
					mfd_pkg::HW_NARROW: begin
						if (w > cap(32'(regs.max_narrow_fields), mfd_pkg::FIELD_LIMIT))
							err = mfd_pkg::ST_OVERSIZE;
						else
							n_narrow = w[6:0];
					end
					default: begin
						if (w > cap(32'(regs.max_body_bytes), mfd_pkg::BODY_LIMIT)) begin
							err = mfd_pkg::ST_OVERSIZE;
						end else begin
							body_len = w[20:0];
							sect = '0;
							phase = section_after(mfd_pkg::PH_HEADER);
						end
					end
					endcase
				end
			end
			mfd_pkg::PH_WIDE, mfd_pkg::PH_NARROW: begin
				wide = (phase == mfd_pkg::PH_WIDE);
				rel = pos - 22'(mfd_pkg::HEADER_BYTES);
				k = wide ? rel[2:0] : {1'b0, pos[1:0]};
				if (k == '0)
					acc = '0;
				acc = acc | (64'(b) << (8 * k));
				if (k == (wide ? 3'd7 : 3'd3)) begin
					expect_item(wide ? mfd_pkg::KIND_WIDE : mfd_pkg::KIND_NARROW, sect[19:0],
						acc, mfd_pkg::ST_OK, 1'b0);
					sect = sect + 1'b1;
					if (sect >= (wide ? 21'(n_wide) : 21'(n_narrow))) begin
						sect = '0;
						phase = section_after(phase);
					end
				end
			end
			mfd_pkg::PH_BODY: begin
				expect_item(mfd_pkg::KIND_BODY, sect[19:0], 64'(b), mfd_pkg::ST_OK, 1'b0);
				sect = sect + 1'b1;
				if (sect >= body_len) begin
					sect = '0;
					phase = mfd_pkg::PH_DONE;
				end
			end
			default: err = mfd_pkg::ST_TRAILING;
			endcase
		end

		if (pos != mfd_pkg::POS_MAX)
			pos = pos + 1'b1;

		// closing status; a short payload wins over any earlier error
		if (last) begin
			if (pos < 22'(mfd_pkg::HEADER_BYTES))
				st = mfd_pkg::ST_TRUNC;
			else if (err != mfd_pkg::ST_OK)
				st = err;
			else if (phase != mfd_pkg::PH_DONE)
				st = mfd_pkg::ST_TRUNC;
			else
				st = mfd_pkg::ST_OK;
			expect_item(mfd_pkg::KIND_STATUS, '0, '0, st, 1'b1);
			clear_frame();
		end
	endtask

	task automatic field_check(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_item();
		mfd_pkg::result_t want;
		if (expected_items.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected item, expected none actual kind %0h index %0h value %0h",
				$time, items.item_kind, items.item_index, items.item_value);
		end else begin
			want = expected_items.pop_front();
			field_check("item_kind", 64'(want.item_kind), 64'(items.item_kind));
			field_check("item_index", 64'(want.item_index), 64'(items.item_index));
			field_check("item_value", want.item_value, items.item_value);
			field_check("status_code", 64'(want.status_code), 64'(items.status_code));
			field_check("is_final", 64'(want.is_final), 64'(items.is_final));
		end
	endtask

	// sample every channel on the clock edge
	always @(posedge clk) begin
		if (!arst_n) begin
			regs = mfd_pkg::CFG_RESET;
			clear_frame();
			expected_items.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
				mfd_pkg::REG_EXPECTED_VERSION:  regs.expected_version = cfg.write_data;
				mfd_pkg::REG_MAX_MESSAGE_TYPE:  regs.max_message_type = cfg.write_data;
				mfd_pkg::REG_MAX_WIDE_FIELDS:   regs.max_wide_fields = cfg.write_data[6:0];
				mfd_pkg::REG_MAX_NARROW_FIELDS: regs.max_narrow_fields = cfg.write_data[6:0];
				mfd_pkg::REG_MAX_BODY_BYTES:    regs.max_body_bytes = cfg.write_data[20:0];
				default: ;
				endcase
			end
			if (bytes.valid && bytes.ready)
				decode_byte(bytes.data_byte, bytes.end_of_payload);
			if (items.valid && items.ready)
				check_item();
		end
		errors <= mismatches;
		pending <= expected_items.size();
	end

endmodule

@@ tb/tb_message_frame_decoder.sv @@
module tb_message_frame_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// random part of the run; the directed payloads add roughly 600 bytes
	localparam int unsigned ITEM_TARGET = 400;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mfd_cfg_if  cfg();
	mfd_byte_if bytes();
	mfd_item_if items();

	int unsigned mismatch_count;
	int unsigned outstanding;

	message_frame_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.bytes  (bytes),
		.items  (items)
	);

	mfd_frame_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.bytes   (bytes),
		.items   (items),
		.errors  (mismatch_count),
		.pending (outstanding)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// settings as last written, used to shape well-formed payloads
	logic [31:0] cur_version;
	logic [31:0] cur_max_type;
	int unsigned lim_wide;
	int unsigned lim_narrow;
	int unsigned lim_body;

	logic [7:0]  frame_q[$];
	int unsigned parsed_bytes = 0;
	int unsigned hold_gap = 0;
	logic        steady = 1'b0;
	int unsigned cycles = 0;

	function automatic int unsigned clip(input logic [31:0] v, input logic [31:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	// mostly short stalls, a few long ones
	function automatic int unsigned stall_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 65)
			return 0;
		return stall_len();
	endfunction

	// output side: random stalls with occasional long stretches of no stall
	logic        sink_ready = 1'b0;
	int unsigned ready_hold = 0;
	assign items.ready = sink_ready;

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 99) < 30) begin
			sink_ready <= 1'b0;
			ready_hold <= stall_len() - 1;
		end else begin
			sink_ready <= 1'b1;
			ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
				: $urandom_range(0, 15);
		end
	end

	// timeout
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_message_frame_decoder: errors");
		$finish;
	end

	task automatic add_byte(input logic [7:0] b);
		frame_q = {frame_q, b};
	endtask

	task automatic write_reg(input logic [mfd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.write_data <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	// write all registers plus one unmapped index
	task automatic apply_setting(input logic [31:0] ver, input logic [31:0] typ,
			input logic [31:0] wid, input logic [31:0] nar, input logic [31:0] bod);
		write_reg(mfd_pkg::REG_EXPECTED_VERSION, ver);
		write_reg(mfd_pkg::REG_MAX_MESSAGE_TYPE, typ);
		write_reg(mfd_pkg::REG_MAX_WIDE_FIELDS, wid);
		write_reg(mfd_pkg::REG_MAX_NARROW_FIELDS, nar);
		write_reg(mfd_pkg::REG_MAX_BODY_BYTES, bod);
		write_reg(mfd_pkg::REG_MAX_BODY_BYTES +
			mfd_pkg::CFG_INDEX_W'(1 + $urandom_range(0, 2)), $urandom);
		cfg.valid <= 1'b0;
		cur_version = ver;
		cur_max_type = typ;
		lim_wide = clip(wid & 32'h7F, mfd_pkg::FIELD_LIMIT);
		lim_narrow = clip(nar & 32'h7F, mfd_pkg::FIELD_LIMIT);
		lim_body = clip(bod & 32'h1F_FFFF, mfd_pkg::BODY_LIMIT);
	endtask

	task automatic random_setting();
		logic [31:0] ver;
		logic [31:0] typ;
		logic [31:0] lim[3];
		case ($urandom_range(0, 2))
		0:       ver = '0;
		1:       ver = '1;
		default: ver = $urandom;
		endcase
		case ($urandom_range(0, 7))
		0:       typ = '0;
		1:       typ = 32'd1;
		2, 3:    typ = $urandom_range(2, 20);
		4:       typ = '1;
		default: typ = $urandom;
		endcase
		for (int i = 0; i < 2; i++) begin
			case ($urandom_range(0, 5))
			0:       lim[i] = $urandom;
			1, 2:    lim[i] = $urandom_range(0, 6);
			3:       lim[i] = 32'd64;
			4:       lim[i] = 32'd65;
			default: lim[i] = 32'd127;
			endcase
		end
		case ($urandom_range(0, 5))
		0:       lim[2] = $urandom;
		1, 2:    lim[2] = $urandom_range(0, 30);
		3:       lim[2] = mfd_pkg::BODY_LIMIT;
		4:       lim[2] = mfd_pkg::BODY_LIMIT + 1;
		default: lim[2] = 32'h1F_FFFF;
		endcase
		apply_setting(ver, typ, lim[0], lim[1], lim[2]);
	endtask

	// drive one byte, hold until taken, then decide the gap before the next
	task automatic send_byte(input logic [7:0] b, input logic eop);
		if (hold_gap != 0)
			repeat (hold_gap) @(posedge clk);
		bytes.valid <= 1'b1;
		bytes.data_byte <= b;
		bytes.end_of_payload <= eop;
		@(posedge clk);
		while (!bytes.ready)
			@(posedge clk);
		hold_gap = steady ? 0 : pick_gap();
		if (hold_gap != 0)
			bytes.valid <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned counted);
		steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
		parsed_bytes += counted;
	endtask

	// drop valid, drain every expected item, then let the pipeline settle
	task automatic wait_idle();
		if (hold_gap == 0)
			bytes.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_le(input logic [63:0] v, input int unsigned n);
		for (int i = 0; i < n; i++)
			add_byte(v[8*i +: 8]);
	endtask

	task automatic header(input logic [31:0] ver, input logic [31:0] typ,
			input logic [31:0] nw, input logic [31:0] nn, input logic [31:0] nb);
		frame_q.delete();
		put_le(64'(ver), 4);
		put_le(64'(typ), 4);
		put_le(64'(nw), 4);
		put_le(64'(nn), 4);
		put_le(64'(nb), 4);
	endtask

	task automatic sections(input int unsigned nw, input int unsigned nn, input int unsigned nb);
		repeat (nw) put_le({$urandom, $urandom}, 8);
		repeat (nn) put_le(64'($urandom), 4);
		repeat (nb) add_byte(8'($urandom));
	endtask

	task automatic noise(input int unsigned n);
		repeat (n) add_byte(8'($urandom));
	endtask

	function automatic int unsigned pick_count(input int unsigned lim);
		if ($urandom_range(0, 39) == 0)
			return lim;
		return $urandom_range(0, (lim < 4) ? lim : 4);
	endfunction

	function automatic int unsigned pick_body();
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(0, (lim_body < 200) ? lim_body : 200);
		return $urandom_range(0, (lim_body < 12) ? lim_body : 12);
	endfunction

	function automatic logic [31:0] pick_type();
		if (cur_max_type == '0)
			return $urandom;
		case ($urandom_range(0, 3))
		0:       return 32'd1;
		1:       return cur_max_type;
		default: return $urandom_range(1, cur_max_type);
		endcase
	endfunction

	// mostly well-formed payloads, then header errors, cut or padded ones, noise
	task automatic random_payload();
		int unsigned mode;
		int unsigned nw;
		int unsigned nn;
		int unsigned nb;
		int unsigned cut;
		logic [31:0] ver;
		logic [31:0] typ;
		logic [31:0] hw;
		logic [31:0] hn;
		logic [31:0] hb;
		mode = $urandom_range(0, 99);
		nw = pick_count(lim_wide);
		nn = pick_count(lim_narrow);
		nb = pick_body();
		ver = cur_version;
		typ = pick_type();
		hw = nw;
		hn = nn;
		hb = nb;
		if (mode < 5) begin
			frame_q.delete();
			noise($urandom_range(1, 30));
			send_frame(4);
		end else if (mode < 25) begin
			case ($urandom_range(0, 4))
			0: ver = cur_version ^ (32'd1 << $urandom_range(0, 31));
			1: typ = (cur_max_type == '1 || $urandom_range(0, 1) == 0) ? '0 : cur_max_type + 1;
			2: hw = lim_wide + 1 + $urandom_range(0, 2);
			3: hn = ($urandom_range(0, 1) == 0) ? lim_narrow + 1 : $urandom | 32'h80;
			default: hb = ($urandom_range(0, 1) == 0) ? lim_body + 1 : $urandom | 32'h20_0000;
			endcase
			header(ver, typ, hw, hn, hb);
			noise($urandom_range(0, 12));
			send_frame(mfd_pkg::HEADER_BYTES);
		end else begin
			header(ver, typ, hw, hn, hb);
			sections(nw, nn, nb);
			if (mode < 35) begin
				cut = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > cut)
					void'(frame_q.pop_back());
			end else if (mode < 42) begin
				noise($urandom_range(1, 3));
			end
			send_frame(frame_q.size());
		end
	endtask

	initial begin
		int unsigned target;
		bytes.valid <= 1'b0;
		bytes.data_byte <= '0;
		bytes.end_of_payload <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.reg_index <= '0;
		cfg.write_data <= '0;
		cur_version = mfd_pkg::CFG_RESET.expected_version;
		cur_max_type = mfd_pkg::CFG_RESET.max_message_type;
		lim_wide = 32'(mfd_pkg::CFG_RESET.max_wide_fields);
		lim_narrow = 32'(mfd_pkg::CFG_RESET.max_narrow_fields);
		lim_body = 32'(mfd_pkg::CFG_RESET.max_body_bytes);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// smallest good payload, then extreme field values
		header(32'd1, 32'd1, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd1, 32'd15, 1, 1, 1);
		put_le('1, 8);
		put_le(64'h0, 4);
		add_byte(8'hFF);
		send_frame(frame_q.size());
		header(32'd1, 32'd2, 1, 1, 1);
		put_le('0, 8);
		put_le(64'hFFFF_FFFF, 4);
		add_byte(8'h00);
		send_frame(frame_q.size());
		header(32'd1, 32'd4, 2, 3, 4);
		sections(2, 3, 4);
		send_frame(frame_q.size());

		// short payloads: single byte, 19 bytes, 19 bytes after a version error
		frame_q.delete();
		add_byte(8'hA5);
		send_frame(1);
		header(32'd1, 32'd1, 0, 0, 0);
		void'(frame_q.pop_back());
		send_frame(frame_q.size());
		header(32'd7, 32'd1, 0, 0, 0);
		void'(frame_q.pop_back());
		send_frame(frame_q.size());

		// header errors, and the first one wins
		header(32'd2, 32'd1, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd1, 32'd0, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd1, 32'd16, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd1, 32'd3, 65, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd1, 32'd3, 0, 65, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd1, 32'd3, 0, 0, mfd_pkg::BODY_LIMIT + 1);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'd5, 32'd0, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);

		// trailing byte, and payloads ending inside a section
		header(32'd1, 32'd1, 0, 0, 0);
		noise(1);
		send_frame(frame_q.size());
		header(32'd1, 32'd1, 2, 0, 0);
		sections(1, 0, 0);
		send_frame(frame_q.size());
		header(32'd1, 32'd1, 0, 0, 5);
		sections(0, 0, 3);
		send_frame(frame_q.size());

		// register values above the size limits act as the limits;
		// a full-size count is taken, so the header alone ends truncated
		wait_idle();
		apply_setting('1, '1, '1, 32'hFFFF_FF80, 32'h1F_FFFF);
		header('1, '1, 64, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header('1, 32'd1, 65, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header('1, 32'd1, 0, 1, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header('1, 32'd1, 0, 0, mfd_pkg::BODY_LIMIT);
		sections(0, 0, 2);
		send_frame(frame_q.size());
		header('1, 32'd1, 0, 0, mfd_pkg::BODY_LIMIT + 1);
		send_frame(mfd_pkg::HEADER_BYTES);

		// a zero type limit rejects every type
		wait_idle();
		apply_setting('0, '0, '0, 32'd64, '0);
		header('0, 32'd1, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);
		header('0, 32'd0, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);

		// smallest nonzero type and field limits, and a zero body limit
		wait_idle();
		apply_setting(32'h1234_5678, 32'd1, 32'd1, 32'd1, '0);
		header(32'h1234_5678, 32'd1, 0, 0, 1);
		send_frame(mfd_pkg::HEADER_BYTES);
		header(32'h1234_5678, 32'd1, 1, 1, 0);
		sections(1, 1, 0);
		send_frame(frame_q.size());
		header(32'h1234_5678, 32'd2, 0, 0, 0);
		send_frame(mfd_pkg::HEADER_BYTES);

		// random payloads over several register settings
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == 0)
				apply_setting(mfd_pkg::CFG_RESET.expected_version,
					mfd_pkg::CFG_RESET.max_message_type,
					32'(mfd_pkg::CFG_RESET.max_wide_fields),
					32'(mfd_pkg::CFG_RESET.max_narrow_fields),
					32'(mfd_pkg::CFG_RESET.max_body_bytes));
			else if (p == PHASES - 2)
				apply_setting('0, 32'd1, 32'd1, 32'd1, 32'd1);
			else if (p == PHASES - 1)
				apply_setting('1, '1, '1, '0, 32'h1F_FFFF);
			else
				random_setting();
			target = parsed_bytes + ITEM_TARGET / PHASES;
			while (parsed_bytes < target)
				random_payload();
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_message_frame_decoder: clean");
		else
			$display("tb_message_frame_decoder: errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/mfd_pkg.sv
sv/mfd_byte_if.sv
sv/mfd_item_if.sv
sv/mfd_cfg_if.sv
sv/mfd_front.sv
sv/mfd_queue.sv
sv/mfd_back.sv
sv/message_frame_decoder.sv
tb/mfd_frame_checker.sv
tb/tb_message_frame_decoder.sv
